@@ hw/rtl/dsfb_pkg.sv @@
// Shared types, codes and constants of the DLE stuffed frame builder.
package dsfb_pkg;

  localparam int SEQ_BYTES     = 4;
  localparam int START_MAX_DEF = 4;
  localparam int END_MAX_DEF   = 4;
  localparam int MAX_RES       = 2 + SEQ_BYTES + 1;
  localparam int CNT_W         = $clog2(MAX_RES + 1);

  localparam logic [7:0] SEED = 8'h55;
  localparam logic [7:0] DLE  = 8'h10;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_PARAM = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_BYTES = 2'd0,
    REG_START_LEN   = 2'd1,
    REG_END_BYTES   = 2'd2,
    REG_END_LEN     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] start_bytes;
    logic [2:0]  start_len;
    logic [31:0] end_bytes;
    logic [2:0]  end_len;
  } cfg_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic [7:0]              flen;
  } burst_t;

endpackage

@@ hw/rtl/dsfb_expand.sv @@
// Expands one accepted transaction into its burst of frame bytes and keeps the frame state.
module dsfb_expand #(
  parameter int START_MAX = dsfb_pkg::START_MAX_DEF,
  parameter int END_MAX   = dsfb_pkg::END_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  input  dsfb_pkg::cfg_t    cfg,
  output dsfb_pkg::burst_t  burst
);

  localparam int START_LIM =
    (START_MAX < dsfb_pkg::SEQ_BYTES) ? START_MAX : dsfb_pkg::SEQ_BYTES;
  localparam int END_LIM =
    (END_MAX < dsfb_pkg::SEQ_BYTES) ? END_MAX : dsfb_pkg::SEQ_BYTES;

  logic [7:0]                 csum_r, csum_nxt;
  logic [7:0]                 cnt_r, cnt_nxt;
  logic [3:0][7:0]            sb, eb;
  logic [dsfb_pkg::CNT_W-1:0] slen, elen, ncs, p, q, n;

  assign sb   = cfg.start_bytes;
  assign eb   = cfg.end_bytes;
  assign slen = (cfg.start_len > 3'(START_LIM)) ? 3'(START_LIM) : cfg.start_len;
  assign elen = (cfg.end_len > 3'(END_LIM)) ? 3'(END_LIM) : cfg.end_len;
  assign ncs  = (csum_r == dsfb_pkg::DLE) ? 3'd2 : 3'd1;

  always_comb begin
    burst    = '0;
    csum_nxt = csum_r;
    cnt_nxt  = cnt_r;
    p        = '0;
    q        = '0;
    n        = '0;
    unique case (cmd)
      dsfb_pkg::CMD_BEGIN: begin
        for (int i = 0; i < dsfb_pkg::MAX_RES; i++) begin
          p = 3'(i);
          if (p < slen) begin
            burst.bytes[i] = sb[p[1:0]];
          end else if (p == slen) begin
            burst.bytes[i] = data_byte;
          end
        end
        n           = slen + 3'd1;
        burst.count = n;
        cnt_nxt     = 8'(slen) + 8'd2;
        csum_nxt    = dsfb_pkg::SEED ^ sb[1] ^ data_byte;
      end
      dsfb_pkg::CMD_PARAM: begin
        burst.bytes[0] = data_byte;
        burst.bytes[1] = dsfb_pkg::DLE;
        n              = (data_byte == dsfb_pkg::DLE) ? 3'd2 : 3'd1;
        burst.count    = n;
        cnt_nxt        = cnt_r + 8'(n);
        csum_nxt       = csum_r ^ data_byte;
      end
      dsfb_pkg::CMD_END: begin
        for (int i = 0; i < dsfb_pkg::MAX_RES; i++) begin
          p = 3'(i);
          q = p - ncs;
          if (p < ncs) begin
            burst.bytes[i] = csum_r;
          end else if (q < elen) begin
            burst.bytes[i] = eb[q[1:0]];
          end else if (q == elen) begin
            burst.bytes[i] = data_byte;
          end
        end
        n           = ncs + elen + 3'd1;
        burst.count = n;
        burst.flen  = cnt_r + 8'(n);
        csum_nxt    = '0;
        cnt_nxt     = '0;
      end
      default: begin
        burst.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      csum_r <= csum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/dsfb_emit.sv @@
// Holds one burst of frame bytes and shifts it out through the output register.
module dsfb_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dsfb_pkg::burst_t burst,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [7:0]       out_frame_length
);

  logic [dsfb_pkg::MAX_RES-1:0][7:0] buf_r, buf_nxt;
  logic [dsfb_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [7:0]                        flen_r, flen_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [7:0]                        out_byte_r, out_flen_r;
  logic                              out_last_r;
  logic                              adv, emit;

  assign adv   = !out_valid_r || out_ready;
  assign emit  = (rem_r != '0) && adv;
  assign ready = (rem_r == '0) || ((rem_r == 3'd1) && adv);

  always_comb begin
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    flen_nxt = flen_r;
    if (emit) begin
      buf_nxt = {8'h00, buf_r[dsfb_pkg::MAX_RES-1:1]};
      rem_nxt = rem_r - 3'd1;
    end
    if (load) begin
      buf_nxt  = burst.bytes;
      rem_nxt  = burst.count;
      flen_nxt = burst.flen;
    end
    out_valid_nxt = adv ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    flen_r <= flen_nxt;
    if (emit) begin
      out_byte_r <= buf_r[0];
      out_last_r <= (rem_r == 3'd1);
      out_flen_r <= (rem_r == 3'd1) ? flen_r : 8'h00;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_frame_length = out_flen_r;

endmodule

@@ hw/rtl/dle_stuffed_frame_builder_unit.sv @@
// Top level of the DLE stuffed frame builder with its configuration registers.
// Each input transaction expands into a burst of 1 to 7 frame bytes that leave one per
// cycle while out_ready is high: a parameter byte produces one byte, or two when it is
// stuffed; a begin item produces start_len + 1; an end item produces 2 + end_len, or
// 3 + end_len when the checksum is stuffed, where start_len and end_len saturate at
// START_MAX and END_MAX, at most four. The first byte passes through the burst buffer
// and then the output register after acceptance. The next transaction is accepted in
// the cycle the previous burst's last byte moves into the output register, so the
// single-byte output serializer sets the rate. A type 3 transaction is accepted and
// dropped. Configuration writes take effect at once and belong between frames.
module dle_stuffed_frame_builder_unit #(
  parameter int START_MAX = dsfb_pkg::START_MAX_DEF,
  parameter int END_MAX   = dsfb_pkg::END_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [7:0]  out_frame_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  dsfb_pkg::cfg_t   cfg_r;
  dsfb_pkg::burst_t burst;
  logic             in_accept;

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsfb_pkg::REG_START_BYTES: cfg_r.start_bytes <= cfg_wdata;
        dsfb_pkg::REG_START_LEN:   cfg_r.start_len   <= cfg_wdata[2:0];
        dsfb_pkg::REG_END_BYTES:   cfg_r.end_bytes   <= cfg_wdata;
        dsfb_pkg::REG_END_LEN:     cfg_r.end_len     <= cfg_wdata[2:0];
      endcase
    end
  end

  dsfb_expand #(
    .START_MAX (START_MAX),
    .END_MAX   (END_MAX)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .cfg       (cfg_r),
    .burst     (burst)
  );

  dsfb_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_accept),
    .burst            (burst),
    .ready            (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_frame_length (out_frame_length)
  );

endmodule

@@ hw/rtl/dsfb_checker.sv @@
// Port-level checks of the DLE stuffed frame builder and their binding to the top level.
module dsfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [7:0] out_frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_frame_length))
    else $error("Output transaction changed while stalled.");

  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last || out_frame_length == 8'h00))
    else $error("Frame length reported on a byte that is not the last of its burst.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind dle_stuffed_frame_builder_unit dsfb_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_last         (out_last),
  .out_frame_length (out_frame_length)
);
